>>> src/quoted_word_splitter_core_macros.svh
// Assertion macros for the quoted word splitter.
// Used by the lexer and the result queue; expects clk_i and rst_ni in scope.
`ifndef QUOTED_WORD_SPLITTER_CORE_MACROS_SVH
`define QUOTED_WORD_SPLITTER_CORE_MACROS_SVH

// same-cycle implication, checked out of reset
`define QWS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define QWS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/qws_pkg.sv
// Shared types and constants of the quoted word splitter.
// No dependencies; imported by the interfaces and all modules.
`default_nettype none

package qws_pkg;

  localparam int CH_W   = 8;  // line byte
  localparam int TOK_W  = 4;  // token_index field
  localparam int POS_W  = 8;  // write_pos field
  localparam int TCNT_W = 5;  // token_count field

  localparam int MAX_TOKENS_DEF = 16;
  localparam int LINE_LEN_DEF   = 256;

  // result queue depth: room for one two-result item behind a stalled sink
  localparam int RES_FIFO_DEPTH = 4;

  localparam logic [CH_W-1:0] CH_NUL    = 8'h00;
  localparam logic [CH_W-1:0] CH_TAB    = 8'h09;
  localparam logic [CH_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [CH_W-1:0] CH_DQUOTE = 8'h22;
  localparam logic [CH_W-1:0] CH_SQUOTE = 8'h27;
  localparam logic [CH_W-1:0] CH_BSLASH = 8'h5C;

  typedef struct packed {
    logic              has_byte;
    logic [CH_W-1:0]   out_byte;
    logic [TOK_W-1:0]  token_index;
    logic [POS_W-1:0]  write_pos;
    logic              line_done;
    logic [TCNT_W-1:0] token_count;
    logic              truncated;
    logic              overflow;
  } res_t;

  // what one lexer step hands to the result queue
  typedef struct packed {
    logic [1:0]       n;
    res_t [1:0]       rec;
  } lex_out_t;

endpackage

`default_nettype wire

>>> src/qws_if.sv
// Valid/ready channel interfaces of the quoted word splitter.
// Depends on qws_pkg for field widths.
`default_nettype none

interface qws_in_if import qws_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);
endinterface

interface qws_out_if import qws_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              has_byte;
  logic [CH_W-1:0]   out_byte;
  logic [TOK_W-1:0]  token_index;
  logic [POS_W-1:0]  write_pos;
  logic              line_done;
  logic [TCNT_W-1:0] token_count;
  logic              truncated;
  logic              overflow;

  modport source (output valid, output has_byte, output out_byte, output token_index,
                  output write_pos, output line_done, output token_count,
                  output truncated, output overflow, input ready);
  modport sink   (input valid, input has_byte, input out_byte, input token_index,
                  input write_pos, input line_done, input token_count,
                  input truncated, input overflow, output ready);
endinterface

`default_nettype wire

>>> src/qws_lexer.sv
// Lexer state and single-step next-state / result logic.
// Depends on qws_pkg and the assertion macro header.
`default_nettype none

module qws_lexer import qws_pkg::*; #(
  parameter int MAX_TOKENS = MAX_TOKENS_DEF,
  parameter int LINE_LEN   = LINE_LEN_DEF
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            step_i,
  input  wire logic [CH_W-1:0] ch_i,
  output lex_out_t             res_o
);

`include "quoted_word_splitter_core_macros.svh"

  localparam int WS_W    = $clog2(MAX_TOKENS + 1);
  localparam int SP_W    = $clog2(LINE_LEN + 1);
  localparam int WS_EXT  = WS_W + TCNT_W;
  localparam int SP_EXT  = SP_W + POS_W;

  typedef enum logic [1:0] {
    MODE_GAP,
    MODE_BARE,
    MODE_SINGLE,
    MODE_DOUBLE
  } lex_mode_e;

  lex_mode_e       mode_q, mode_n, mode_d;
  logic            esc_q, esc_n, esc_d;
  logic [WS_W-1:0] ws_q, ws_n, ws_d;
  logic [SP_W-1:0] sp_q, sp_n, sp_d;
  logic            disc_q, disc_n, disc_d;
  logic            trunc_q, trunc_n, trunc_d;
  logic            ovf_q, ovf_n, ovf_d;

  logic [1:0]      req_n;
  logic [CH_W-1:0] req0, req1;
  logic            done;
  logic            take;
  logic            ok0, ok1, fail;
  logic [1:0]      n_ok;
  logic [WS_W-1:0] tok_src;
  logic [WS_EXT-1:0] tok_ext, cnt_ext;
  logic [SP_EXT-1:0] sp_ext;
  logic [POS_W-1:0]  pos8;

  // lexing: up to two scratch write requests per byte
  always_comb begin
    mode_n  = mode_q;
    esc_n   = esc_q;
    ws_n    = ws_q;
    disc_n  = disc_q;
    trunc_n = trunc_q;
    req_n   = 2'd0;
    req0    = CH_NUL;
    req1    = CH_NUL;
    done    = 1'b0;
    take    = 1'b0;
    if (ch_i == CH_NUL) begin
      done = 1'b1;
      if (esc_q) begin
        req0  = CH_BSLASH;
        req_n = 2'd1;
      end
      if (mode_q != MODE_GAP && !disc_q) begin
        if (req_n == 2'd1) begin
          req1 = CH_NUL;
        end else begin
          req0 = CH_NUL;
        end
        req_n = req_n + 2'd1;
      end
    end else if (disc_q) begin
      take = 1'b0;
    end else if (esc_q) begin
      req0  = ch_i;
      req_n = 2'd1;
      esc_n = 1'b0;
    end else begin
      take = 1'b1;
      if (mode_q == MODE_GAP) begin
        if (ch_i inside {CH_SPACE, CH_TAB}) begin
          take = 1'b0;
        end else if (ws_q >= WS_W'(MAX_TOKENS)) begin
          trunc_n = 1'b1;
          disc_n  = 1'b1;
          take    = 1'b0;
        end else begin
          ws_n = ws_q + 1'b1;
          if (ch_i == CH_SQUOTE) begin
            mode_n = MODE_SINGLE;
            take   = 1'b0;
          end else if (ch_i == CH_DQUOTE) begin
            mode_n = MODE_DOUBLE;
            take   = 1'b0;
          end else begin
            mode_n = MODE_BARE;
          end
        end
      end
      if (take) begin
        case (mode_n)
          MODE_BARE: begin
            if (ch_i inside {CH_SPACE, CH_TAB}) begin
              req0   = CH_NUL;
              req_n  = 2'd1;
              mode_n = MODE_GAP;
            end else if (ch_i == CH_SQUOTE) begin
              mode_n = MODE_SINGLE;
            end else if (ch_i == CH_DQUOTE) begin
              mode_n = MODE_DOUBLE;
            end else if (ch_i == CH_BSLASH) begin
              esc_n = 1'b1;
            end else begin
              req0  = ch_i;
              req_n = 2'd1;
            end
          end
          MODE_SINGLE: begin
            if (ch_i == CH_SQUOTE) begin
              mode_n = MODE_BARE;
            end else begin
              req0  = ch_i;
              req_n = 2'd1;
            end
          end
          MODE_DOUBLE: begin
            if (ch_i == CH_DQUOTE) begin
              mode_n = MODE_BARE;
            end else if (ch_i == CH_BSLASH) begin
              esc_n = 1'b1;
            end else begin
              req0  = ch_i;
              req_n = 2'd1;
            end
          end
          default: begin
            mode_n = mode_q;
          end
        endcase
      end
    end
  end

  // scratch space: once a write misses, the position pins at the line length
  assign ok0  = (req_n != 2'd0) && (sp_q < SP_W'(LINE_LEN));
  assign ok1  = (req_n == 2'd2) && (sp_q < SP_W'(LINE_LEN - 1));
  assign n_ok = ok1 ? 2'd2 : (ok0 ? 2'd1 : 2'd0);
  assign fail = (req_n != n_ok);
  assign ovf_n = ovf_q | fail;
  assign sp_n  = fail ? SP_W'(LINE_LEN) : sp_q + SP_W'(n_ok);

  assign tok_src = (ws_n != '0) ? ws_n - 1'b1 : '0;
  assign tok_ext = WS_EXT'(tok_src);
  assign cnt_ext = WS_EXT'(ws_n);
  assign sp_ext  = SP_EXT'(sp_q);
  assign pos8    = sp_ext[POS_W-1:0];

  always_comb begin
    res_o = '0;
    for (int k = 0; k < 2; k++) begin
      res_o.rec[k].token_count = cnt_ext[TCNT_W-1:0];
      res_o.rec[k].truncated   = trunc_n;
      res_o.rec[k].overflow    = ovf_n;
    end
    res_o.n = (done && n_ok == 2'd0) ? 2'd1 : n_ok;
    if (ok0) begin
      res_o.rec[0].has_byte    = 1'b1;
      res_o.rec[0].out_byte    = req0;
      res_o.rec[0].token_index = tok_ext[TOK_W-1:0];
      res_o.rec[0].write_pos   = pos8;
    end
    res_o.rec[0].line_done   = done && !ok1;
    res_o.rec[1].has_byte    = 1'b1;
    res_o.rec[1].out_byte    = req1;
    res_o.rec[1].token_index = tok_ext[TOK_W-1:0];
    res_o.rec[1].write_pos   = pos8 + 1'b1;
    res_o.rec[1].line_done   = done;
  end

  // line end returns everything to reset
  always_comb begin
    mode_d  = done ? MODE_GAP : mode_n;
    esc_d   = done ? 1'b0 : esc_n;
    ws_d    = done ? '0 : ws_n;
    sp_d    = done ? '0 : sp_n;
    disc_d  = done ? 1'b0 : disc_n;
    trunc_d = done ? 1'b0 : trunc_n;
    ovf_d   = done ? 1'b0 : ovf_n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_GAP;
      esc_q   <= 1'b0;
      ws_q    <= '0;
      sp_q    <= '0;
      disc_q  <= 1'b0;
      trunc_q <= 1'b0;
      ovf_q   <= 1'b0;
    end else if (step_i) begin
      mode_q  <= mode_d;
      esc_q   <= esc_d;
      ws_q    <= ws_d;
      sp_q    <= sp_d;
      disc_q  <= disc_d;
      trunc_q <= trunc_d;
      ovf_q   <= ovf_d;
    end
  end

  `QWS_ASSERT_IMPL(a_esc_in_word, esc_q, (mode_q != MODE_GAP) && !disc_q, "escape outside a word")
  `QWS_ASSERT_IMPL(a_ws_cap, 1'b1, ws_q <= WS_W'(MAX_TOKENS), "word count past limit")
  `QWS_ASSERT_NEXT(a_line_reset, step_i && (ch_i == CH_NUL),
                   (ws_q == '0) && (sp_q == '0) && (mode_q == MODE_GAP), "line end left state")

endmodule

`default_nettype wire

>>> src/qws_res_fifo.sv
// Result queue: takes up to two results per cycle, gives one per cycle while the sink is ready.
// Depends on qws_pkg and the assertion macro header.
`default_nettype none

module qws_res_fifo import qws_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  wire lex_out_t data_i,
  output logic          room_o,
  output logic          valid_o,
  input  wire logic     ready_i,
  output res_t          head_o
);

`include "quoted_word_splitter_core_macros.svh"

  localparam int PTR_W  = $clog2(RES_FIFO_DEPTH);
  localparam int FILL_W = $clog2(RES_FIFO_DEPTH + 1);

  res_t              mem_q [RES_FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_q, wr_d, wr_p1, rd_q, rd_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic [1:0]        push_n;
  logic              pop;

  assign push_n  = push_i ? data_i.n : 2'd0;
  assign pop     = valid_o && ready_i;
  assign valid_o = (fill_q != '0);
  assign head_o  = mem_q[rd_q];
  // room for a full two-result step, ignoring a pop in the same cycle
  assign room_o  = (fill_q <= FILL_W'(RES_FIFO_DEPTH - 2));

  assign wr_p1  = wr_q + 1'b1;
  assign wr_d   = wr_q + PTR_W'(push_n);
  assign rd_d   = rd_q + PTR_W'(pop);
  assign fill_d = fill_q + FILL_W'(push_n) - FILL_W'(pop);

  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) begin
      mem_q[wr_q] <= data_i.rec[0];
    end
    if (push_n == 2'd2) begin
      mem_q[wr_p1] <= data_i.rec[1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      wr_q   <= wr_d;
      rd_q   <= rd_d;
      fill_q <= fill_d;
    end
  end

  `QWS_ASSERT_IMPL(a_fill_bound, 1'b1, fill_q <= FILL_W'(RES_FIFO_DEPTH), "queue overfilled")
  `QWS_ASSERT_IMPL(a_push_room, push_n != 2'd0, room_o, "push without room")
  `QWS_ASSERT_NEXT(a_fill_track, 1'b1,
                   fill_q == $past(fill_q) + FILL_W'($past(push_n)) - FILL_W'($past(pop)),
                   "fill count drifted")

endmodule

`default_nettype wire

>>> src/quoted_word_splitter_core.sv
// Top level of the quoted word splitter: input register, lexer, result queue.
// Depends on qws_pkg, qws_if, qws_lexer and qws_res_fifo.
//
//   channel | dir | payload                                  | results per item
//   --------+-----+------------------------------------------+-----------------
//   in_i    | in  | ch                                       | -
//   out_o   | out | has_byte out_byte token_index write_pos  | 0, 1 or 2
//           |     | line_done token_count truncated overflow |
//
// One byte per cycle while the queue has room; a byte's first result goes through
// the input register, then the lexer step writes it into the result queue, whose
// head drives the output port.
// A line end with a pending backslash gives two results if the scratch buffer has
// room for both; input stalls only when the 4-entry queue has under 2 free.
// Asynchronous active-low reset clears all lexer state and the queue; no sweep.
// Output stalls back up through the queue and the input register.
`default_nettype none

module quoted_word_splitter_core import qws_pkg::*; #(
  parameter int MAX_TOKENS = MAX_TOKENS_DEF,
  parameter int LINE_LEN   = LINE_LEN_DEF
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  qws_in_if.sink      in_i,
  qws_out_if.source   out_o
);

  logic            s1_valid_q, s1_valid_d;
  logic [CH_W-1:0] s1_ch_q;
  logic            s1_fire;
  logic            in_fire;
  logic            room;
  lex_out_t        lex_res;
  res_t            head;

  // the held byte moves on whenever the queue can take two results
  assign s1_fire    = s1_valid_q && room;
  assign in_i.ready = !s1_valid_q || s1_fire;
  assign in_fire    = in_i.valid && in_i.ready;
  assign s1_valid_d = in_fire || (s1_valid_q && !s1_fire);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_ch_q <= in_i.ch;
    end
  end

  qws_lexer #(
    .MAX_TOKENS (MAX_TOKENS),
    .LINE_LEN   (LINE_LEN)
  ) u_lexer (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (s1_fire),
    .ch_i   (s1_ch_q),
    .res_o  (lex_res)
  );

  qws_res_fifo u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (s1_fire),
    .data_i  (lex_res),
    .room_o  (room),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .head_o  (head)
  );

  assign out_o.has_byte    = head.has_byte;
  assign out_o.out_byte    = head.out_byte;
  assign out_o.token_index = head.token_index;
  assign out_o.write_pos   = head.write_pos;
  assign out_o.line_done   = head.line_done;
  assign out_o.token_count = head.token_count;
  assign out_o.truncated   = head.truncated;
  assign out_o.overflow    = head.overflow;

endmodule

`default_nettype wire

>>> tb/quoted_word_splitter_core_test.sv
// Self-checking testbench for quoted_word_splitter_core: drives command lines byte by byte,
// predicts every scratch write and line-end item, and checks them in order.
// Depends on qws_pkg, qws_if and the RTL of quoted_word_splitter_core.
`default_nettype none

module quoted_word_splitter_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import qws_pkg::*;

  localparam int SHORT_BUDGET = 300;   // bytes of ordinary lines after the directed part
  localparam int STALL_LIMIT  = 1000;  // cycles without any handshake before giving up
  localparam int DRAIN_CYCLES = 16;    // results pass the input register and the result queue; watch a while for strays

  // Scoreboard: carries its own lexer state and the queue of scratch writes still owed.
  class line_board;
    typedef enum logic [1:0] {LX_GAP, LX_BARE, LX_SINGLE, LX_DOUBLE} lex_mode_e;

    lex_mode_e mode;
    bit        esc_pend;
    bit        discard;
    bit        trunc_f;
    bit        ovf_f;
    int        words;
    int        pos;
    res_t      step_q[$];    // writes produced by the byte under evaluation
    res_t      writes_q[$];  // writes predicted but not yet seen on the output
    int        errors;
    int        checked;
    int        lines;
    int        trunc_lines;
    int        ovf_lines;

    function new();
      restart();
    endfunction

    function void restart();
      mode     = LX_GAP;
      esc_pend = 1'b0;
      discard  = 1'b0;
      trunc_f  = 1'b0;
      ovf_f    = 1'b0;
      words    = 0;
      pos      = 0;
    endfunction

    function bit is_blank(logic [7:0] c);
      return c == CH_SPACE || c == CH_TAB;
    endfunction

    // scratch write; past the end of the buffer it is dropped and flagged
    function void write_byte(logic [7:0] b);
      res_t r;
      if (pos < LINE_LEN_DEF && step_q.size() < 2) begin
        r             = '0;
        r.has_byte    = 1'b1;
        r.out_byte    = b;
        r.token_index = TOK_W'(words > 0 ? words - 1 : 0);
        r.write_pos   = POS_W'(pos);
        step_q.push_back(r);
        pos++;
      end else begin
        ovf_f = 1'b1;
        pos   = LINE_LEN_DEF;
      end
    endfunction

    // one byte inside an open word
    function void lex_in_word(logic [7:0] c);
      case (mode)
        LX_BARE: begin
          if (is_blank(c)) begin
            write_byte(CH_NUL);
            mode = LX_GAP;
          end else if (c == CH_SQUOTE) begin
            mode = LX_SINGLE;
          end else if (c == CH_DQUOTE) begin
            mode = LX_DOUBLE;
          end else if (c == CH_BSLASH) begin
            esc_pend = 1'b1;
          end else begin
            write_byte(c);
          end
        end
        LX_SINGLE: begin
          if (c == CH_SQUOTE) mode = LX_BARE;
          else write_byte(c);
        end
        default: begin
          if (c == CH_DQUOTE) mode = LX_BARE;
          else if (c == CH_BSLASH) esc_pend = 1'b1;
          else write_byte(c);
        end
      endcase
    endfunction

    // accepted input item: work out the writes it causes and queue them
    function void note_byte(logic [7:0] c);
      bit   line_end;
      res_t r;
      step_q.delete();
      line_end = (c == CH_NUL);
      if (line_end) begin
        if (esc_pend) write_byte(CH_BSLASH);
        if (mode != LX_GAP && !discard) write_byte(CH_NUL);
        if (step_q.size() == 0) begin
          r = '0;
          step_q.push_back(r);
        end
      end else if (discard) begin
      end else if (esc_pend) begin
        write_byte(c);
        esc_pend = 1'b0;
      end else if (mode == LX_GAP) begin
        if (is_blank(c)) begin
        end else if (words >= MAX_TOKENS_DEF) begin
          trunc_f = 1'b1;
          discard = 1'b1;
        end else begin
          words++;
          if (c == CH_SQUOTE) mode = LX_SINGLE;
          else if (c == CH_DQUOTE) mode = LX_DOUBLE;
          else begin
            mode = LX_BARE;
            lex_in_word(c);
          end
        end
      end else begin
        lex_in_word(c);
      end
      foreach (step_q[i]) begin
        r             = step_q[i];
        r.line_done   = line_end && (i == step_q.size() - 1);
        r.token_count = TCNT_W'(words);
        r.truncated   = trunc_f;
        r.overflow    = ovf_f;
        writes_q.push_back(r);
      end
      if (line_end) begin
        lines++;
        trunc_lines += trunc_f;
        ovf_lines   += ovf_f;
        restart();
      end
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    task cmp(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want)
        report($sformatf("result %0d %s got 0x%0h want 0x%0h", checked, name, got, want));
    endtask

    task check_result(res_t got);
      res_t want;
      if (writes_q.size() == 0) begin
        report($sformatf("unexpected result 0x%0h", got));
        return;
      end
      want = writes_q.pop_front();
      cmp("has_byte",    got.has_byte,    want.has_byte);
      cmp("out_byte",    got.out_byte,    want.out_byte);
      cmp("token_index", got.token_index, want.token_index);
      cmp("write_pos",   got.write_pos,   want.write_pos);
      cmp("line_done",   got.line_done,   want.line_done);
      cmp("token_count", got.token_count, want.token_count);
      cmp("truncated",   got.truncated,   want.truncated);
      cmp("overflow",    got.overflow,    want.overflow);
      checked++;
    endtask
  endclass

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #1 clk_i = ~clk_i;

  qws_in_if  in_if ();
  qws_out_if out_if ();

  quoted_word_splitter_core u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  line_board  board;
  logic [7:0] line_q[$];   // line under construction, line end not included
  int         in_gap_max;  // 0 gives a back-to-back burst
  int         out_gap_max;
  int         sent;
  int         idle_cycles = 0;

  // ---------------------------------------------------------------------------
  // Input side. Valid stays high across back-to-back items; it is lowered only
  // when an idle gap is drawn, so it never toggles twice within one edge.
  // ---------------------------------------------------------------------------
  task automatic send_byte(logic [7:0] b);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.ch    <= b;
    // sampled right after the edge, i.e. the values the block saw at it
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    board.note_byte(b);
    sent++;
  endtask

  // each line gets its own pacing: a quarter of lines go out as solid bursts
  task automatic send_line();
    in_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 9;
    foreach (line_q[i]) send_byte(line_q[i]);
    send_byte(CH_NUL);
    line_q.delete();
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
    send_line();
  endtask

  // ---------------------------------------------------------------------------
  // Line generators. Mostly well-formed shell text with random content so the
  // quoting and escape states are exercised deeply; some raw noise on top.
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] any_byte();
    return 8'($urandom_range(1, 255));
  endfunction

  // a byte with no lexical meaning
  function automatic logic [7:0] plain_byte();
    logic [7:0] c;
    do c = any_byte();
    while (c inside {CH_SPACE, CH_TAB, CH_SQUOTE, CH_DQUOTE, CH_BSLASH});
    return c;
  endfunction

  function automatic void add_blanks();
    int n;
    n = $urandom_range(1, 3);
    repeat (n) line_q.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
  endfunction

  function automatic void add_word(int pieces);
    int         k;
    int         n;
    logic [7:0] c;
    repeat (pieces) begin
      k = $urandom_range(0, 9);
      if (k <= 5) begin
        line_q.push_back(plain_byte());
      end else if (k == 6) begin
        // escape in bare text, any byte following
        line_q.push_back(CH_BSLASH);
        line_q.push_back(any_byte());
      end else if (k == 7) begin
        // single quotes: everything but the closing quote is literal
        line_q.push_back(CH_SQUOTE);
        n = $urandom_range(0, 4);
        repeat (n) begin
          do c = any_byte(); while (c == CH_SQUOTE);
          line_q.push_back(c);
        end
        line_q.push_back(CH_SQUOTE);
      end else if (k == 8) begin
        // double quotes with blanks, stray single quotes and escapes inside
        line_q.push_back(CH_DQUOTE);
        n = $urandom_range(0, 4);
        repeat (n) begin
          case ($urandom_range(0, 3))
            0: begin
              line_q.push_back(CH_BSLASH);
              line_q.push_back(any_byte());
            end
            1: line_q.push_back($urandom_range(0, 1) ? CH_SPACE : CH_SQUOTE);
            default: line_q.push_back(plain_byte());
          endcase
        end
        line_q.push_back(CH_DQUOTE);
      end else begin
        // empty quote pair
        c = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
        line_q.push_back(c);
        line_q.push_back(c);
      end
    end
  endfunction

  function automatic void build_short(int nwords);
    logic [7:0] q;
    if ($urandom_range(0, 3) == 0) add_blanks();
    for (int i = 0; i < nwords; i++) begin
      if (i > 0) add_blanks();
      add_word($urandom_range(1, 5));
    end
    case ($urandom_range(0, 5))
      0: add_blanks();
      1: line_q.push_back(CH_BSLASH);   // dangling backslash at line end
      2: begin
        // quote left open at line end
        q = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
        line_q.push_back(q);
        repeat ($urandom_range(0, 3)) line_q.push_back(plain_byte());
      end
      default: ;
    endcase
  endfunction

  function automatic void build_noise();
    int n;
    n = $urandom_range(1, 20);
    repeat (n) begin
      case ($urandom_range(0, 7))
        0: line_q.push_back(CH_SPACE);
        1: line_q.push_back(CH_SQUOTE);
        2: line_q.push_back(CH_DQUOTE);
        3: line_q.push_back(CH_BSLASH);
        default: line_q.push_back(any_byte());
      endcase
    end
  endfunction

  // one long bare word; a trailing blank leaves the line end with nothing to write
  function automatic void build_long(int chars, bit tail_blank);
    repeat (chars) line_q.push_back(plain_byte());
    if (tail_blank) line_q.push_back(CH_SPACE);
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int start;
    int k;
    board = new();
    in_if.valid  <= 1'b0;
    in_if.ch     <= '0;
    in_gap_max   = 0;
    sent         = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed lines
    send_text("");                 // empty line: lone line-end item
    send_text("a\tb\\");           // tab split, backslash right before line end
    send_text("'q");               // unterminated single quote
    send_text("\"a\\\"");          // escaped quote leaves double quote open
    send_text(" ''");              // leading blank, empty quoted word
    line_q.push_back(8'h01);       // smallest and largest bytes
    line_q.push_back(8'hFF);
    send_line();
    send_text("x\\ y");            // escaped blank stays in the word

    // scratch buffer edges: exact fit, then overrun
    build_long(LINE_LEN_DEF - 1, 1'b0);
    send_line();
    build_long($urandom_range(LINE_LEN_DEF, LINE_LEN_DEF + 24), 1'($urandom_range(0, 1)));
    send_line();

    // random lines; some cross the word limit
    start = sent;
    while (sent - start < SHORT_BUDGET) begin
      k = $urandom_range(0, 99);
      if (k < 8) build_short($urandom_range(MAX_TOKENS_DEF - 1, MAX_TOKENS_DEF + 4));
      else if (k < 80) build_short($urandom_range(1, 6));
      else build_noise();
      send_line();
    end
    in_if.valid <= 1'b0;

    while (board.writes_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("run covered %0d lines, %0d bytes in, %0d output items checked",
             board.lines, sent, board.checked);
    $display("%0d lines hit the word limit, %0d overran the scratch buffer",
             board.trunc_lines, board.ovf_lines);
    if (board.errors == 0 && board.writes_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Output side: stall pattern changes every few dozen items, including
  // stretches with ready held high.
  initial begin
    int gap;
    int quota;
    out_if.ready <= 1'b0;
    quota = 0;
    out_gap_max = 0;
    wait (rst_ni === 1'b1);
    forever begin
      if (quota == 0) begin
        out_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 9;
        quota       = $urandom_range(10, 40);
      end
      quota--;
      gap = $urandom_range(0, out_gap_max);
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (out_if.valid !== 1'b1);
      board.check_result({out_if.has_byte, out_if.out_byte, out_if.token_index,
                          out_if.write_pos, out_if.line_done, out_if.token_count,
                          out_if.truncated, out_if.overflow});
    end
  end

  // Watchdog: any handshake on either side counts as progress.
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == STALL_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
      $display("TB_ERROR");
      $finish;
    end
  end

endmodule

`default_nettype wire
